/* rtl/vgsp_pkg.sv */
// Shared types, codes and constants of the voxel grid shape painter.
`timescale 1ns / 1ps

package vgsp_pkg;

    // Default grid size on each axis; each axis may be 1 to 64 voxels.
    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    // Grid coordinate width, wide enough for the largest supported axis.
    localparam int CW = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int COLOR_W     = 32;

    // Command codes on s_action.
    localparam logic [2:0] ACT_SET_VOXEL  = 3'd0;
    localparam logic [2:0] ACT_CLR_VOXEL  = 3'd1;
    localparam logic [2:0] ACT_SET_SPHERE = 3'd2;
    localparam logic [2:0] ACT_CLR_SPHERE = 3'd3;
    localparam logic [2:0] ACT_SET_BOX    = 3'd4;
    localparam logic [2:0] ACT_CLR_BOX    = 3'd5;
    localparam logic [2:0] ACT_READ_VOXEL = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_RED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_GREEN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_BLUE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT_ALPHA = 8'd3;

    // What the back end does with a queued command.
    typedef enum logic [1:0] {
        KIND_RESULT = 2'd0,   // answer at once, store untouched
        KIND_READ   = 2'd1,   // read one voxel
        KIND_FILL   = 2'd2    // walk a box of voxels, optionally sphere-tested
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               status;
        logic               set;
        logic               sphere;
        logic [CW-1:0]      x0;
        logic [CW-1:0]      x1;
        logic [CW-1:0]      y0;
        logic [CW-1:0]      y1;
        logic [CW-1:0]      z0;
        logic [CW-1:0]      z1;
        logic signed [7:0]  cx;
        logic signed [7:0]  cy;
        logic signed [7:0]  cz;
        logic [13:0]        r2;
    } cmd_t;

    typedef struct packed {
        logic       status;
        logic       voxel_on;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } res_t;

endpackage

/* rtl/vgsp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module vgsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/vgsp_front.sv */
// Front end: accepts commands, checks and clips coordinates, builds queue entries.
`timescale 1ns / 1ps

module vgsp_front #(
    parameter int GRID_X = vgsp_pkg::GRID_X_DEF,
    parameter int GRID_Y = vgsp_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vgsp_pkg::GRID_Z_DEF
) (
    input  logic               init_done,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [7:0]  s_first_x,
    input  logic signed [7:0]  s_first_y,
    input  logic signed [7:0]  s_first_z,
    input  logic signed [7:0]  s_last_x,
    input  logic signed [7:0]  s_last_y,
    input  logic signed [7:0]  s_last_z,
    input  logic [6:0]         s_sphere_radius,
    output logic               q_push,
    input  logic               q_ready,
    output vgsp_pkg::cmd_t     q_data
);

    function automatic logic in_axis(input logic signed [7:0] v, input int n);
        in_axis = (v >= 0) && (v < n);
    endfunction

    function automatic logic signed [8:0] clip_lo(input logic signed [7:0] v);
        clip_lo = (v < 0) ? 9'sd0 : 9'(v);
    endfunction

    function automatic logic signed [8:0] clip_hi(input logic signed [7:0] v, input int n);
        clip_hi = (v > n - 1) ? 9'(n - 1) : 9'(v);
    endfunction

    logic              in_grid;
    logic signed [8:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic              box_empty;
    logic [13:0]       rad_ext;

    assign s_ready = init_done && q_ready;
    assign q_push  = s_valid && s_ready;

    assign in_grid = in_axis(s_first_x, GRID_X) && in_axis(s_first_y, GRID_Y) &&
                     in_axis(s_first_z, GRID_Z);

    assign lo_x = clip_lo(s_first_x);
    assign lo_y = clip_lo(s_first_y);
    assign lo_z = clip_lo(s_first_z);
    assign hi_x = clip_hi(s_last_x, GRID_X);
    assign hi_y = clip_hi(s_last_y, GRID_Y);
    assign hi_z = clip_hi(s_last_z, GRID_Z);
    assign box_empty = (lo_x > hi_x) || (lo_y > hi_y) || (lo_z > hi_z);
    assign rad_ext = 14'(s_sphere_radius);

    always_comb begin
        q_data        = '0;
        q_data.kind   = vgsp_pkg::KIND_RESULT;
        q_data.cx     = s_first_x;
        q_data.cy     = s_first_y;
        q_data.cz     = s_first_z;
        q_data.r2     = rad_ext * rad_ext;
        case (s_action)
            vgsp_pkg::ACT_SET_VOXEL, vgsp_pkg::ACT_CLR_VOXEL, vgsp_pkg::ACT_READ_VOXEL: begin
                if (!in_grid) begin
                    q_data.status = 1'b1;
                end else begin
                    q_data.kind = (s_action == vgsp_pkg::ACT_READ_VOXEL) ?
                                  vgsp_pkg::KIND_READ : vgsp_pkg::KIND_FILL;
                    q_data.set  = (s_action == vgsp_pkg::ACT_SET_VOXEL);
                    q_data.x0   = s_first_x[vgsp_pkg::CW-1:0];
                    q_data.x1   = s_first_x[vgsp_pkg::CW-1:0];
                    q_data.y0   = s_first_y[vgsp_pkg::CW-1:0];
                    q_data.y1   = s_first_y[vgsp_pkg::CW-1:0];
                    q_data.z0   = s_first_z[vgsp_pkg::CW-1:0];
                    q_data.z1   = s_first_z[vgsp_pkg::CW-1:0];
                end
            end
            vgsp_pkg::ACT_SET_SPHERE, vgsp_pkg::ACT_CLR_SPHERE: begin
                q_data.kind   = vgsp_pkg::KIND_FILL;
                q_data.set    = (s_action == vgsp_pkg::ACT_SET_SPHERE);
                q_data.sphere = 1'b1;
                q_data.x1     = vgsp_pkg::CW'(GRID_X - 1);
                q_data.y1     = vgsp_pkg::CW'(GRID_Y - 1);
                q_data.z1     = vgsp_pkg::CW'(GRID_Z - 1);
            end
            vgsp_pkg::ACT_SET_BOX, vgsp_pkg::ACT_CLR_BOX: begin
                if (!box_empty) begin
                    q_data.kind = vgsp_pkg::KIND_FILL;
                    q_data.set  = (s_action == vgsp_pkg::ACT_SET_BOX);
                    q_data.x0   = lo_x[vgsp_pkg::CW-1:0];
                    q_data.x1   = hi_x[vgsp_pkg::CW-1:0];
                    q_data.y0   = lo_y[vgsp_pkg::CW-1:0];
                    q_data.y1   = hi_y[vgsp_pkg::CW-1:0];
                    q_data.z0   = lo_z[vgsp_pkg::CW-1:0];
                    q_data.z1   = hi_z[vgsp_pkg::CW-1:0];
                end
            end
            default: begin
                q_data.kind = vgsp_pkg::KIND_RESULT;
            end
        endcase
    end

endmodule

/* rtl/vgsp_queue.sv */
// Small command FIFO between the front and back ends.
`timescale 1ns / 1ps

module vgsp_queue #(
    parameter int DEPTH = vgsp_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    output logic           in_ready,
    input  vgsp_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           pop,
    output vgsp_pkg::cmd_t out_data
);

    localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    vgsp_pkg::cmd_t  entry_reg [DEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_pop;

    assign in_ready  = (count_reg != CNTW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/vgsp_back.sv */
// Back end: clears the store after reset, walks fills, serves reads, holds the result beat.
`timescale 1ns / 1ps

module vgsp_back #(
    parameter int GRID_X = vgsp_pkg::GRID_X_DEF,
    parameter int GRID_Y = vgsp_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vgsp_pkg::GRID_Z_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    output logic                           init_done,
    input  logic                           cfg_we,
    input  logic [vgsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  vgsp_pkg::cmd_t                 q_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output vgsp_pkg::res_t                 m_res
);

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PLANE = GRID_Y * GRID_Z;
    localparam int CW    = vgsp_pkg::CW;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SWEEP = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_RDATA = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
        addr_of = AW'(int'(x) * PLANE + int'(y) * GRID_Z + int'(z));
    endfunction

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    vgsp_pkg::cmd_t cmd_reg, cmd_next;
    logic [CW-1:0]  cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [7:0]     red_reg, green_reg, blue_reg, alpha_reg;

    // one register stage between the voxel walk and the store write
    logic           p1_valid_reg;
    logic [AW-1:0]  p1_addr_reg;
    logic [15:0]    p1_dx2_reg, p1_dy2_reg, p1_dz2_reg;
    logic signed [8:0]  dx, dy, dz;
    logic signed [17:0] sqx, sqy, sqz;
    logic [16:0]    dist2;
    logic           p1_hit;

    logic           m_valid_reg, m_valid_next;
    vgsp_pkg::res_t res_reg, res_next;
    logic           out_free;
    logic           walk_last;

    logic           on_we, col_we;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [0:0]     on_wdata, on_rdata;
    logic [vgsp_pkg::COLOR_W-1:0] col_wdata, col_rdata;

    assign init_done = (state_reg != ST_CLEAR);
    assign q_pop     = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign walk_last = (cx_reg == cmd_reg.x1) && (cy_reg == cmd_reg.y1) &&
                       (cz_reg == cmd_reg.z1);

    assign dx  = $signed(9'(cx_reg)) - $signed({cmd_reg.cx[7], cmd_reg.cx});
    assign dy  = $signed(9'(cy_reg)) - $signed({cmd_reg.cy[7], cmd_reg.cy});
    assign dz  = $signed(9'(cz_reg)) - $signed({cmd_reg.cz[7], cmd_reg.cz});
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;

    assign dist2  = {1'b0, p1_dx2_reg} + {1'b0, p1_dy2_reg} + {1'b0, p1_dz2_reg};
    assign p1_hit = !cmd_reg.sphere || (dist2 <= 17'(cmd_reg.r2));

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_data;
                    cx_next  = q_data.x0;
                    cy_next  = q_data.y0;
                    cz_next  = q_data.z0;
                    case (q_data.kind)
                        vgsp_pkg::KIND_READ: state_next = ST_READ;
                        vgsp_pkg::KIND_FILL: state_next = ST_SWEEP;
                        default:             state_next = ST_RESP;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end else if (cz_reg == cmd_reg.z1) begin
                    cz_next = cmd_reg.z0;
                    if (cy_reg == cmd_reg.y1) begin
                        cy_next = cmd_reg.y0;
                        cx_next = cx_reg + 1'b1;
                    end else begin
                        cy_next = cy_reg + 1'b1;
                    end
                end else begin
                    cz_next = cz_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_READ: begin
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                if (out_free) begin
                    res_next.status   = 1'b0;
                    res_next.voxel_on = on_rdata[0];
                    res_next.red      = col_rdata[31:24];
                    res_next.green    = col_rdata[23:16];
                    res_next.blue     = col_rdata[15:8];
                    res_next.alpha    = col_rdata[7:0];
                    m_valid_next      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    res_next        = '0;
                    res_next.status = cmd_reg.status;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            red_reg      <= '0;
            green_reg    <= '0;
            blue_reg     <= '0;
            alpha_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
            p1_valid_reg <= (state_reg == ST_SWEEP);
            if (cfg_we) begin
                case (cfg_index)
                    vgsp_pkg::REG_PAINT_RED:   red_reg   <= cfg_data;
                    vgsp_pkg::REG_PAINT_GREEN: green_reg <= cfg_data;
                    vgsp_pkg::REG_PAINT_BLUE:  blue_reg  <= cfg_data;
                    vgsp_pkg::REG_PAINT_ALPHA: alpha_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        res_reg     <= res_next;
        p1_addr_reg <= addr_of(cx_reg, cy_reg, cz_reg);
        p1_dx2_reg  <= sqx[15:0];
        p1_dy2_reg  <= sqy[15:0];
        p1_dz2_reg  <= sqz[15:0];
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            on_we     = 1'b1;
            col_we    = 1'b1;
            wr_addr   = clr_reg;
            on_wdata  = 1'b0;
            col_wdata = '0;
        end else begin
            on_we     = p1_valid_reg && p1_hit;
            col_we    = p1_valid_reg && p1_hit && cmd_reg.set;
            wr_addr   = p1_addr_reg;
            on_wdata  = cmd_reg.set;
            col_wdata = {red_reg, green_reg, blue_reg, alpha_reg};
        end
    end

    assign rd_addr = addr_of(cmd_reg.x0, cmd_reg.y0, cmd_reg.z0);

    vgsp_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_on_ram (
        .aclk    (aclk),
        .wr_en   (on_we),
        .wr_addr (wr_addr),
        .wr_data (on_wdata),
        .rd_addr (rd_addr),
        .rd_data (on_rdata)
    );

    vgsp_ram #(
        .WIDTH (vgsp_pkg::COLOR_W),
        .DEPTH (DEPTH)
    ) u_color_ram (
        .aclk    (aclk),
        .wr_en   (col_we),
        .wr_addr (wr_addr),
        .wr_data (col_wdata),
        .rd_addr (rd_addr),
        .rd_data (col_rdata)
    );

endmodule

/* rtl/voxel_grid_shape_painter.sv */
// Top level of the voxel grid shape painter.
//
// Keeps a GRID_X x GRID_Y x GRID_Z voxel store (on mark plus RGBA8 color).
// Input channel s_*: one command beat per item (set/clear voxel, sphere or
// box, read voxel). Result channel m_*: exactly one result beat per command,
// in command order. Config channel cfg_*: writes the paint color registers
// 0..3 (red, green, blue, alpha); always ready, other indexes are dropped.
// After reset a clearing pass writes every voxel (GRID_X*GRID_Y*GRID_Z, 32768
// at the default size); s_ready stays low until it ends. A single voxel write
// walks one voxel, a read does one store read, a box walks its clipped voxels
// and a sphere walks the whole grid. The walk issues one store access per
// cycle and sets the rate. A two-entry command queue lets the input side keep
// accepting while the back end walks or while a result waits; when the
// receiver stalls, the result beat holds in the output register and the queue
// fills, after which s_ready drops.
`timescale 1ns / 1ps

module voxel_grid_shape_painter #(
    parameter int GRID_X = vgsp_pkg::GRID_X_DEF,
    parameter int GRID_Y = vgsp_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vgsp_pkg::GRID_Z_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vgsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_action,
    input  logic signed [7:0]              s_first_x,
    input  logic signed [7:0]              s_first_y,
    input  logic signed [7:0]              s_first_z,
    input  logic signed [7:0]              s_last_x,
    input  logic signed [7:0]              s_last_y,
    input  logic signed [7:0]              s_last_z,
    input  logic [6:0]                     s_sphere_radius,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_status,
    output logic                           m_voxel_on,
    output logic [7:0]                     m_voxel_red,
    output logic [7:0]                     m_voxel_green,
    output logic [7:0]                     m_voxel_blue,
    output logic [7:0]                     m_voxel_alpha
);

    logic           init_done;
    logic           q_push, q_in_ready, q_out_valid, q_pop;
    vgsp_pkg::cmd_t q_in_data, q_out_data;
    vgsp_pkg::res_t res;

    assign cfg_ready = 1'b1;

    vgsp_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .init_done       (init_done),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_first_x       (s_first_x),
        .s_first_y       (s_first_y),
        .s_first_z       (s_first_z),
        .s_last_x        (s_last_x),
        .s_last_y        (s_last_y),
        .s_last_z        (s_last_z),
        .s_sphere_radius (s_sphere_radius),
        .q_push          (q_push),
        .q_ready         (q_in_ready),
        .q_data          (q_in_data)
    );

    vgsp_queue #(
        .DEPTH (vgsp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .pop       (q_pop),
        .out_data  (q_out_data)
    );

    vgsp_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_out_valid),
        .q_pop     (q_pop),
        .q_data    (q_out_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_status      = res.status;
    assign m_voxel_on    = res.voxel_on;
    assign m_voxel_red   = res.red;
    assign m_voxel_green = res.green;
    assign m_voxel_blue  = res.blue;
    assign m_voxel_alpha = res.alpha;

endmodule

/* dv/voxel_grid_shape_painter_test.sv */
// Self-checking bench for the voxel grid shape painter with a voxel store predictor.
`timescale 1ns / 1ps

module voxel_grid_shape_painter_test;
    import vgsp_pkg::*;

    localparam int GX     = GRID_X_DEF;
    localparam int GY     = GRID_Y_DEF;
    localparam int GZ     = GRID_Z_DEF;
    localparam int VOXELS = GX * GY * GZ;
    localparam int VAW    = $clog2(VOXELS);

    localparam logic [2:0]           ACT_UNUSED   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 8'hFF;

    // Longest quiet stretch: one full-grid walk plus the longest receiver stall, with margin.
    localparam int STALL_LIMIT   = 150000;
    localparam int SETTLE_CYCLES = 50;

    typedef enum logic [1:0] {
        STEP_CMD,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [2:0]           action;
        logic signed [7:0]    fx;
        logic signed [7:0]    fy;
        logic signed [7:0]    fz;
        logic signed [7:0]    lx;
        logic signed [7:0]    ly;
        logic signed [7:0]    lz;
        logic [6:0]           radius;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [7:0]           reg_val;
    } step_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_action  = '0;
    logic signed [7:0]    s_first_x = '0;
    logic signed [7:0]    s_first_y = '0;
    logic signed [7:0]    s_first_z = '0;
    logic signed [7:0]    s_last_x  = '0;
    logic signed [7:0]    s_last_y  = '0;
    logic signed [7:0]    s_last_z  = '0;
    logic [6:0]           s_sphere_radius = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_status;
    logic                 m_voxel_on;
    logic [7:0]           m_voxel_red;
    logic [7:0]           m_voxel_green;
    logic [7:0]           m_voxel_blue;
    logic [7:0]           m_voxel_alpha;

    step_t command_plan [$];
    res_t  owed_replies [$];

    bit        voxel_lit [VOXELS];
    bit [31:0] voxel_hue [VOXELS];
    bit [7:0]  paint_reg [4];

    int  errors         = 0;
    int  quiet_cycles   = 0;
    int  tx_gap         = 0;
    int  rx_hold        = 0;
    bit  tx_calm        = 1'b0;
    bit  rx_calm        = 1'b0;
    bit  cmd_beat       = 1'b0;
    bit  cfg_beat       = 1'b0;
    bit  res_beat       = 1'b0;
    int  spheres_left   = 4;
    int  big_boxes_left = 3;

    voxel_grid_shape_painter #(
        .GRID_X(GX),
        .GRID_Y(GY),
        .GRID_Z(GZ)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_first_z      (s_first_z),
        .s_last_x       (s_last_x),
        .s_last_y       (s_last_y),
        .s_last_z       (s_last_z),
        .s_sphere_radius(s_sphere_radius),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_voxel_on     (m_voxel_on),
        .m_voxel_red    (m_voxel_red),
        .m_voxel_green  (m_voxel_green),
        .m_voxel_blue   (m_voxel_blue),
        .m_voxel_alpha  (m_voxel_alpha)
    );

    always #5 aclk = ~aclk;

    function automatic logic [VAW-1:0] voxel_addr(int x, int y, int z);
        return VAW'((x * GY + y) * GZ + z);
    endfunction

    function automatic void mark_voxel(logic [VAW-1:0] a, bit set);
        voxel_lit[a] = set;
        if (set) begin
            voxel_hue[a] = {paint_reg[REG_PAINT_RED[1:0]], paint_reg[REG_PAINT_GREEN[1:0]],
                            paint_reg[REG_PAINT_BLUE[1:0]], paint_reg[REG_PAINT_ALPHA[1:0]]};
        end
    endfunction

    // Updates the voxel store copy and returns the reply the command earns.
    function automatic res_t apply_command(logic [2:0] act, logic signed [7:0] fx,
                                           logic signed [7:0] fy, logic signed [7:0] fz,
                                           logic signed [7:0] lx, logic signed [7:0] ly,
                                           logic signed [7:0] lz, logic [6:0] rad);
        res_t           r;
        int             cx, cy, cz, ux, uy, uz, x0, y0, z0, x1, y1, z1, rr, i, j, k;
        logic [VAW-1:0] a;
        r  = '0;
        cx = int'(fx);
        cy = int'(fy);
        cz = int'(fz);
        ux = int'(lx);
        uy = int'(ly);
        uz = int'(lz);
        rr = int'(rad);
        case (act)
            ACT_SET_VOXEL, ACT_CLR_VOXEL, ACT_READ_VOXEL: begin
                if (cx < 0 || cy < 0 || cz < 0 || cx >= GX || cy >= GY || cz >= GZ) begin
                    r.status = 1'b1;
                end else begin
                    a = voxel_addr(cx, cy, cz);
                    if (act == ACT_READ_VOXEL) begin
                        r.voxel_on = voxel_lit[a];
                        {r.red, r.green, r.blue, r.alpha} = voxel_hue[a];
                    end else begin
                        mark_voxel(a, act == ACT_SET_VOXEL);
                    end
                end
            end
            ACT_SET_SPHERE, ACT_CLR_SPHERE: begin
                for (i = 0; i < GX; i++)
                    for (j = 0; j < GY; j++)
                        for (k = 0; k < GZ; k++)
                            if ((i - cx) * (i - cx) + (j - cy) * (j - cy) + (k - cz) * (k - cz)
                                    <= rr * rr)
                                mark_voxel(voxel_addr(i, j, k), act == ACT_SET_SPHERE);
            end
            ACT_SET_BOX, ACT_CLR_BOX: begin
                x0 = (cx < 0) ? 0 : cx;
                y0 = (cy < 0) ? 0 : cy;
                z0 = (cz < 0) ? 0 : cz;
                x1 = (ux > GX - 1) ? GX - 1 : ux;
                y1 = (uy > GY - 1) ? GY - 1 : uy;
                z1 = (uz > GZ - 1) ? GZ - 1 : uz;
                for (i = x0; i <= x1; i++)
                    for (j = y0; j <= y1; j++)
                        for (k = z0; k <= z1; k++)
                            mark_voxel(voxel_addr(i, j, k), act == ACT_SET_BOX);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic int idle_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int near_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 7);
        if (r < 9)
            return $urandom_range(0, GX - 1);
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    task automatic add_cmd(logic [2:0] act, int fx, int fy, int fz,
                           int lx, int ly, int lz, int rad);
        step_t st;
        st        = '0;
        st.kind   = STEP_CMD;
        st.action = act;
        st.fx     = 8'(fx);
        st.fy     = 8'(fy);
        st.fz     = 8'(fz);
        st.lx     = 8'(lx);
        st.ly     = 8'(ly);
        st.lz     = 8'(lz);
        st.radius = 7'(rad);
        command_plan.insert(command_plan.size(), st);
    endtask

    task automatic add_paint(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        step_t st;
        st         = '0;
        st.kind    = STEP_CFG;
        st.reg_idx = idx;
        st.reg_val = val;
        command_plan.insert(command_plan.size(), st);
    endtask

    task automatic add_drain();
        step_t st;
        st      = '0;
        st.kind = STEP_DRAIN;
        command_plan.insert(command_plan.size(), st);
    endtask

    task automatic add_random_command();
        int         pick, ax, ay, az, bx, by, bz, rad;
        logic [2:0] act;
        pick = $urandom_range(0, 99);
        ax   = any_coord();
        ay   = any_coord();
        az   = any_coord();
        bx   = any_coord();
        by   = any_coord();
        bz   = any_coord();
        rad  = $urandom_range(0, 127);
        if (pick < 30) begin
            act = ACT_READ_VOXEL;
            ax  = near_coord();
            ay  = near_coord();
            az  = near_coord();
        end else if (pick < 50) begin
            act = $urandom_range(0, 1) ? ACT_SET_VOXEL : ACT_CLR_VOXEL;
            ax  = near_coord();
            ay  = near_coord();
            az  = near_coord();
        end else if (pick < 78) begin
            act = $urandom_range(0, 1) ? ACT_SET_BOX : ACT_CLR_BOX;
            if (big_boxes_left > 0 && $urandom_range(0, 9) == 0) begin
                big_boxes_left--;
            end else begin
                ax = int'($urandom_range(0, 14)) - 3;
                ay = int'($urandom_range(0, 14)) - 3;
                az = int'($urandom_range(0, GZ + 2)) - 3;
                bx = ax + int'($urandom_range(0, 4));
                by = ay + int'($urandom_range(0, 4));
                bz = az + int'($urandom_range(0, 4));
            end
        end else if (pick < 84 && spheres_left > 0) begin
            spheres_left--;
            act = $urandom_range(0, 1) ? ACT_SET_SPHERE : ACT_CLR_SPHERE;
            ax  = int'($urandom_range(0, 40)) - 4;
            ay  = int'($urandom_range(0, 40)) - 4;
            az  = int'($urandom_range(0, 40)) - 4;
            if ($urandom_range(0, 3) != 0)
                rad = $urandom_range(0, 10);
        end else if (pick < 88) begin
            act = ACT_UNUSED;
        end else begin
            act = $urandom_range(0, 1) ? ACT_READ_VOXEL : ACT_SET_VOXEL;
        end
        add_cmd(act, ax, ay, az, bx, by, bz, rad);
    endtask

    // Sender: one beat in flight on either channel, taken from the plan in order.
    always @(negedge aclk) begin : send_side
        step_t st;
        logic  sv, cv;
        sv = s_valid;
        cv = cfg_valid;
        if (sv && cmd_beat) begin
            sv     = 1'b0;
            tx_gap = idle_len(tx_calm);
        end
        if (cv && cfg_beat)
            cv = 1'b0;
        if (aresetn && !sv && !cv) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (command_plan.size() > 0) begin
                st = command_plan[0];
                case (st.kind)
                    STEP_DRAIN: begin
                        if (owed_replies.size() == 0)
                            void'(command_plan.pop_front());
                    end
                    STEP_CFG: begin
                        void'(command_plan.pop_front());
                        cv = 1'b1;
                        cfg_index <= st.reg_idx;
                        cfg_data  <= st.reg_val;
                    end
                    default: begin
                        void'(command_plan.pop_front());
                        sv = 1'b1;
                        s_action        <= st.action;
                        s_first_x       <= st.fx;
                        s_first_y       <= st.fy;
                        s_first_z       <= st.fz;
                        s_last_x        <= st.lx;
                        s_last_y        <= st.ly;
                        s_last_z        <= st.lz;
                        s_sphere_radius <= st.radius;
                    end
                endcase
            end
        end
        s_valid   <= sv;
        cfg_valid <= cv;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
    end

    always @(negedge aclk) begin : take_side
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_hold = idle_len(rx_calm);
        end
        if ($urandom_range(0, 63) == 0)
            rx_calm = !rx_calm;
    end

    always @(posedge aclk) begin : observe
        res_t want;
        cmd_beat = aresetn && s_valid && s_ready;
        cfg_beat = aresetn && cfg_valid && cfg_ready;
        res_beat = aresetn && m_valid && m_ready;
        if (cfg_beat && cfg_index <= REG_PAINT_ALPHA)
            paint_reg[cfg_index[1:0]] = cfg_data;
        if (cmd_beat) begin
            owed_replies.insert(owed_replies.size(),
                                apply_command(s_action, s_first_x, s_first_y, s_first_z,
                                              s_last_x, s_last_y, s_last_z,
                                              s_sphere_radius));
        end
        if (res_beat) begin
            if (owed_replies.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
            end else begin
                want = owed_replies.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("voxel_on", 32'(want.voxel_on), 32'(m_voxel_on));
                check_field("voxel_red", 32'(want.red), 32'(m_voxel_red));
                check_field("voxel_green", 32'(want.green), 32'(m_voxel_green));
                check_field("voxel_blue", 32'(want.blue), 32'(m_voxel_blue));
                check_field("voxel_alpha", 32'(want.alpha), 32'(m_voxel_alpha));
            end
        end
        if (cmd_beat || cfg_beat || res_beat)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase, n;

        // paint registers still at reset
        add_cmd(ACT_READ_VOXEL, 1, 1, 1, 0, 0, 0, 0);
        add_cmd(ACT_SET_VOXEL, 1, 1, 1, -128, -128, -128, 127);
        add_cmd(ACT_READ_VOXEL, 1, 1, 1, 127, 127, 127, 0);

        add_drain();
        add_paint(REG_PAINT_RED, 8'hFF);
        add_paint(REG_PAINT_GREEN, 8'h00);
        add_paint(REG_PAINT_BLUE, 8'h80);
        add_paint(REG_PAINT_ALPHA, 8'h01);
        add_paint(REG_UNMAPPED, 8'h55);
        add_paint(REG_TOP, 8'hAA);

        add_cmd(ACT_SET_VOXEL, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_SET_VOXEL, GX - 1, GY - 1, GZ - 1, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, GX - 1, GY - 1, GZ - 1, 0, 0, 0, 0);
        // single voxel off the grid
        add_cmd(ACT_SET_VOXEL, -1, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_CLR_VOXEL, 0, GY, 0, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, 0, 0, -128, 0, 0, 0, 0);
        // clear keeps the color
        add_cmd(ACT_CLR_VOXEL, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0);
        // box clipped from both extremes
        add_cmd(ACT_SET_BOX, -128, -128, -128, 127, 127, 127, 0);
        add_cmd(ACT_CLR_BOX, 4, 4, 4, 6, 5, 4, 0);
        add_cmd(ACT_SET_BOX, 10, 10, 10, 9, 20, 20, 0);
        add_cmd(ACT_READ_VOXEL, 4, 4, 4, 0, 0, 0, 0);
        add_cmd(ACT_UNUSED, -1, -1, -1, -1, -1, -1, 127);

        add_drain();
        add_paint(REG_PAINT_RED, 8'h00);
        add_paint(REG_PAINT_GREEN, 8'hFF);
        add_paint(REG_PAINT_BLUE, 8'h7F);
        add_paint(REG_PAINT_ALPHA, 8'hFE);

        // sphere entirely off the grid touches nothing
        add_cmd(ACT_CLR_SPHERE, -128, -128, -128, 0, 0, 0, 127);
        add_cmd(ACT_READ_VOXEL, 0, 0, 1, 0, 0, 0, 0);
        add_cmd(ACT_CLR_SPHERE, -5, 0, 0, 0, 0, 0, 20);
        add_cmd(ACT_READ_VOXEL, 10, 0, 0, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, 15, 12, 0, 0, 0, 0, 0);
        add_cmd(ACT_SET_SPHERE, 16, 16, 16, 0, 0, 0, 3);
        add_cmd(ACT_READ_VOXEL, 16, 16, 19, 0, 0, 0, 0);
        add_cmd(ACT_SET_SPHERE, 2, 2, 2, 0, 0, 0, 0);
        add_cmd(ACT_READ_VOXEL, 2, 2, 2, 0, 0, 0, 0);

        for (phase = 0; phase < 3; phase++) begin
            add_drain();
            add_paint(REG_PAINT_RED, 8'($urandom_range(0, 255)));
            add_paint(REG_PAINT_GREEN, 8'($urandom_range(0, 255)));
            add_paint(REG_PAINT_BLUE, 8'($urandom_range(0, 255)));
            add_paint(REG_PAINT_ALPHA, 8'($urandom_range(0, 255)));
            add_paint(CFG_IDX_W'($urandom_range(REG_UNMAPPED, REG_TOP)),
                      8'($urandom_range(0, 255)));
            for (n = 0; n < 25; n++)
                add_random_command();
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (command_plan.size() != 0 || s_valid || cfg_valid || owed_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0 && owed_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/vgsp_pkg.sv
rtl/vgsp_ram.sv
rtl/vgsp_front.sv
rtl/vgsp_queue.sv
rtl/vgsp_back.sv
rtl/voxel_grid_shape_painter.sv
dv/voxel_grid_shape_painter_test.sv
